// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the E - sin E block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EMSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("emsp check failed");
`define EMSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("emsp check failed");
`else
`define EMSP_ASSERT_IMP(lbl, ante, cons)
`define EMSP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/emsp_pkg.sv -----
`default_nettype none
package emsp_pkg;

  localparam int W             = 64;
  localparam int FW            = 60;
  localparam int ANG_W         = 32;
  localparam int OUT_W         = 48;
  localparam int IN_FRAC_BITS  = 30;
  localparam int OUT_FRAC_BITS = 46;
  localparam int E_SH          = FW - IN_FRAC_BITS;
  localparam int OUT_SH        = FW - OUT_FRAC_BITS;
  localparam int E6_SH         = 68;
  localparam int NSIDE         = 5;
  localparam int NLANE         = 3;

  localparam logic [63:0] PI_Q62      = 64'hC90FDAA22168C234;
  localparam logic [ANG_W-1:0] ANG_MAX = ANG_W'(PI_Q62 >> (62 - IN_FRAC_BITS));
  localparam logic [W-1:0] SMALL_LIMIT = 64'd11529215046068469;
  localparam logic [W-1:0] MID_LIMIT   = 64'd230584300921369395;

  localparam int RCP_W    = 96;
  localparam int MUL_LAT  = 2;
  localparam int CDIV_LAT = 4;
  localparam int DIV_LAT  = W;
  localparam int BACK_LAT = 5 * MUL_LAT + CDIV_LAT + DIV_LAT + 4;

  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = 1;
  localparam int CNT_W      = 2;

  // Reciprocals of the fixed divisors, 2^RCP_W / d rounded up. With this
  // scale the truncated product equals the exact quotient for every dividend
  // below 2^RCP_W / d.
  localparam logic [RCP_W-1:0] RCP_6        = RCP_W'(((128'd1 << RCP_W) + 128'd5) / 128'd6);
  localparam logic [RCP_W-1:0] RCP_15       = RCP_W'(((128'd1 << RCP_W) + 128'd14) / 128'd15);
  localparam logic [RCP_W-1:0] RCP_5040     =
    RCP_W'(((128'd1 << RCP_W) + 128'd5039) / 128'd5040);
  localparam logic [RCP_W-1:0] RCP_362880   =
    RCP_W'(((128'd1 << RCP_W) + 128'd362879) / 128'd362880);
  localparam logic [RCP_W-1:0] RCP_72       = RCP_W'(((128'd1 << RCP_W) + 128'd71) / 128'd72);
  localparam logic [RCP_W-1:0] RCP_17160    =
    RCP_W'(((128'd1 << RCP_W) + 128'd17159) / 128'd17160);
  localparam logic [RCP_W-1:0] RCP_57120    =
    RCP_W'(((128'd1 << RCP_W) + 128'd57119) / 128'd57120);
  localparam logic [RCP_W-1:0] RCP_39070080 =
    RCP_W'(((128'd1 << RCP_W) + 128'd39070079) / 128'd39070080);
  localparam logic [RCP_W-1:0] RCP_8910720  =
    RCP_W'(((128'd1 << RCP_W) + 128'd8910719) / 128'd8910720);
  localparam logic [RCP_W-1:0] RCP_19535040 =
    RCP_W'(((128'd1 << RCP_W) + 128'd19535039) / 128'd19535040);

  // Shift that turns the fold numerator into a Q.92-relative dividend.
  localparam int FSH_SMALL = 32;
  localparam int FSH_MID   = 36;
  localparam int FSH_WIDE  = 44;

  localparam logic [1:0] LANE_A = 2'd0;
  localparam logic [1:0] LANE_B = 2'd1;
  localparam logic [1:0] LANE_C = 2'd2;

  typedef enum logic [1:0] {
    RNG_SMALL = 2'd0,
    RNG_MID   = 2'd1,
    RNG_WIDE  = 2'd2
  } rng_t;

  typedef struct packed {
    rng_t             rng;
    logic [ANG_W-1:0] ang;
  } item_t;

  typedef struct packed {
    rng_t                    rng;
    logic [W-1:0]            e;
    logic [NSIDE-1:0][W-1:0] w;
  } side_t;

  typedef struct packed {
    logic         qbit;
    logic [W-1:0] rem;
  } step_t;

  typedef struct packed {
    logic [W-1:0]     k;
    logic [RCP_W-1:0] rcp;
    logic             minus;
  } fold_t;

  function automatic logic [W-1:0] sub0(input logic [W-1:0] a, input logic [W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // One restoring division step: shift in one dividend bit, subtract if it fits.
  function automatic step_t div_step(input logic [W-1:0] rem, input logic nb,
                                     input logic [W-1:0] d);
    step_t      s;
    logic [W:0] t;
    t = {rem, nb};
    if (t >= {1'b0, d}) begin
      s.qbit = 1'b1;
      s.rem  = W'(t - {1'b0, d});
    end else begin
      s.qbit = 1'b0;
      s.rem  = t[W-1:0];
    end
    return s;
  endfunction

  // Outer constant, reciprocal of the inner divisor and sign of each nested fold.
  function automatic fold_t fold_const(input logic [1:0] lane, input rng_t rng);
    fold_t f;
    f.k     = 64'd1;
    f.rcp   = '0;
    f.minus = 1'b0;
    if (lane == LANE_A) begin
      if (rng == RNG_WIDE) begin
        f.k   = 64'd3603600;
        f.rcp = RCP_39070080;
      end
    end else if (lane == LANE_B) begin
      if (rng == RNG_SMALL) begin
        f.k   = 64'd42;
        f.rcp = RCP_72;
      end else if (rng == RNG_MID) begin
        f.k     = 64'd3024;
        f.rcp   = RCP_17160;
        f.minus = 1'b1;
      end else begin
        f.k   = 64'd332640;
        f.rcp = RCP_8910720;
      end
    end else begin
      if (rng == RNG_MID) begin
        f.k     = 64'd7920;
        f.rcp   = RCP_57120;
        f.minus = 1'b1;
      end else if (rng == RNG_WIDE) begin
        f.k   = 64'd1235520;
        f.rcp = RCP_19535040;
      end
    end
    return f;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/emsp_front.sv -----
`default_nettype none
module emsp_front import emsp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ANG_W-1:0] in_angle,
  output logic                  q_wvld,
  output item_t                 q_wdata,
  input  wire logic             q_full
);

  logic             f_vld_r;
  item_t            f_item_r;
  item_t            f_item_nxt;
  logic             push;
  logic [ANG_W-1:0] ang_c;
  logic [W-1:0]     e_c;

  assign push     = f_vld_r && !q_full;
  assign in_ready = !f_vld_r || push;
  assign q_wvld   = f_vld_r;
  assign q_wdata  = f_item_r;

  always_comb begin
    ang_c = (in_angle > ANG_MAX) ? ANG_MAX : in_angle;
    e_c   = W'(ang_c) << E_SH;
    f_item_nxt.ang = ang_c;
    if (e_c <= SMALL_LIMIT) begin
      f_item_nxt.rng = RNG_SMALL;
    end else if (e_c <= MID_LIMIT) begin
      f_item_nxt.rng = RNG_MID;
    end else begin
      f_item_nxt.rng = RNG_WIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_vld_r <= 1'b1;
    end else if (push) begin
      f_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/emsp_fifo.sv -----
`default_nettype none
module emsp_fifo import emsp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_wvld,
  input  wire item_t q_wdata,
  output logic       q_full,
  output logic       q_rvld,
  output item_t      q_rdata,
  input  wire logic  q_pop
);

  item_t            mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;

  assign q_full  = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign q_rvld  = (cnt_r != '0);
  assign q_rdata = mem_r[rp_r];
  assign push    = q_wvld && !q_full;
  assign pop     = q_pop && q_rvld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= q_wdata;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/emsp_mul.sv -----
`default_nettype none
module emsp_mul import emsp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire side_t        side_i,
  output logic [2*W-1:0]    p,
  output side_t             side_o
);

  localparam int H = W / 2;

  logic [W-1:0]   ll_r, lh_r, hl_r, hh_r;
  side_t          side_r;
  logic [2*W-1:0] p_r;
  side_t          side2_r;
  logic [2*W-1:0] mid;

  assign mid    = (2*W)'(lh_r) + (2*W)'(hl_r);
  assign p      = p_r;
  assign side_o = side2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r    <= a[H-1:0] * b[H-1:0];
      lh_r    <= a[H-1:0] * b[W-1:H];
      hl_r    <= a[W-1:H] * b[H-1:0];
      hh_r    <= a[W-1:H] * b[W-1:H];
      side_r  <= side_i;
      p_r     <= {hh_r, ll_r} + (mid << H);
      side2_r <= side_r;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/emsp_div.sv -----
`default_nettype none
module emsp_div import emsp_pkg::*; (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [2*W-1:0] num,
  input  wire logic [W-1:0]   den,
  input  wire side_t          side_i,
  output logic [W-1:0]        quo,
  output side_t               side_o
);

  // One quotient bit per stage. A quotient that needs more than W bits
  // is flagged up front and comes out as all ones.
  logic [W-1:0] rem_r  [DIV_LAT];
  logic [W-1:0] low_r  [DIV_LAT];
  logic [W-1:0] quo_r  [DIV_LAT];
  logic [W-1:0] den_r  [DIV_LAT];
  logic         ovf_r  [DIV_LAT];
  side_t        side_r [DIV_LAT];
  step_t        st     [DIV_LAT];

  always_comb begin
    st[0] = div_step(num[2*W-1:W], num[W-1], den);
    for (int k = 1; k < DIV_LAT; k++) begin
      st[k] = div_step(rem_r[k-1], low_r[k-1][W-1], den_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= st[0].rem;
      low_r[0]  <= num[W-1:0] << 1;
      quo_r[0]  <= W'(st[0].qbit);
      den_r[0]  <= den;
      ovf_r[0]  <= (num[2*W-1:W] >= den);
      side_r[0] <= side_i;
      for (int k = 1; k < DIV_LAT; k++) begin
        rem_r[k]  <= st[k].rem;
        low_r[k]  <= low_r[k-1] << 1;
        quo_r[k]  <= {quo_r[k-1][W-2:0], st[k].qbit};
        den_r[k]  <= den_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign quo    = ovf_r[DIV_LAT-1] ? '1 : quo_r[DIV_LAT-1];
  assign side_o = side_r[DIV_LAT-1];

endmodule

module emsp_cdiv import emsp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [RCP_W-1:0] num,
  input  wire logic [RCP_W-1:0] rcp,
  input  wire side_t            side_i,
  output logic [W-1:0]          quo,
  output side_t                 side_o
);

  // Division by a constant as num * rcp / 2^RCP_W, rcp being the reciprocal
  // rounded up. Nine 32 by 32 partial products are summed by columns, then
  // in two halves, then once more.
  localparam int H  = W / 2;
  localparam int CW = W + 2;
  localparam int AW = 2 * RCP_W;

  logic [W-1:0]  pp_r    [3][3];
  logic [CW-1:0] col_r   [5];
  logic [CW-1:0] col_nxt [5];
  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, acc;
  logic [W-1:0]  quo_r;
  side_t         side_r  [CDIV_LAT];

  always_comb begin
    col_nxt[0] = CW'(pp_r[0][0]);
    col_nxt[1] = CW'(pp_r[0][1]) + CW'(pp_r[1][0]);
    col_nxt[2] = CW'(pp_r[0][2]) + CW'(pp_r[1][1]) + CW'(pp_r[2][0]);
    col_nxt[3] = CW'(pp_r[1][2]) + CW'(pp_r[2][1]);
    col_nxt[4] = CW'(pp_r[2][2]);
    lo_nxt     = AW'(col_r[0]) + (AW'(col_r[1]) << H) + (AW'(col_r[2]) << (2*H));
    hi_nxt     = AW'(col_r[3]) + (AW'(col_r[4]) << H);
    acc        = lo_r + (hi_r << (3*H));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_r[i][j] <= num[H*i +: H] * rcp[H*j +: H];
        end
      end
      for (int k = 0; k < 5; k++) begin
        col_r[k] <= col_nxt[k];
      end
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      quo_r     <= acc[RCP_W+W-1:RCP_W];
      side_r[0] <= side_i;
      for (int k = 1; k < CDIV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign quo    = quo_r;
  assign side_o = side_r[CDIV_LAT-1];

endmodule
`default_nettype wire

// ----- hw/rtl/emsp_back.sv -----
`default_nettype none
module emsp_back import emsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_rvld,
  input  wire item_t       q_rdata,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [OUT_W-1:0] out_e_minus_sin
);

  logic                en;
  logic [BACK_LAT-1:0] vld_r;
  logic                out_vld_r;
  logic [OUT_W-1:0]    out_data_r;

  // Whole pipeline advances together; it only halts when the result waits.
  assign en        = !out_vld_r || out_ready;
  assign q_pop     = en && q_rvld;
  assign out_valid = out_vld_r;
  assign out_e_minus_sin = out_data_r;

  // Powers of E.
  side_t          s0, s0o, s1, s1o, s2, s2o;
  logic [2*W-1:0] p0, p1, p2a, p2b;
  logic [W-1:0]   e2, e4, e6, e8;

  always_comb begin
    s0     = '0;
    s0.rng = q_rdata.rng;
    s0.e   = W'(q_rdata.ang) << E_SH;
  end

  emsp_mul u_m0 (.clk, .en, .a(s0.e), .b(s0.e), .side_i(s0), .p(p0), .side_o(s0o));

  always_comb begin
    s1      = s0o;
    s1.w[0] = p0[FW+W-1:FW];
  end

  emsp_mul u_m1 (.clk, .en, .a(s1.w[0]), .b(s1.w[0]), .side_i(s1), .p(p1),
                 .side_o(s1o));

  always_comb begin
    s2      = s1o;
    s2.w[1] = p1[2*W-1:W];
  end

  emsp_mul u_m2a (.clk, .en, .a(s2.w[1]), .b(s2.w[0]), .side_i(s2), .p(p2a),
                  .side_o(s2o));
  emsp_mul u_m2b (.clk, .en, .a(s2.w[1]), .b(s2.w[1]), .side_i('0), .p(p2b),
                  .side_o());

  assign e2 = s2o.w[0];
  assign e4 = s2o.w[1];
  assign e6 = W'(p2a[2*W-1:E6_SH]);
  assign e8 = p2b[2*W-1:W];

  // Series terms and inner quotients of the folds.
  side_t        s3, s3o;
  logic [W-1:0] ysrc;
  logic [W-1:0] r1_q, b_q, c_q, a_q;
  logic [W-1:0] y_q [NLANE];

  always_comb begin
    s3     = '0;
    s3.rng = s2o.rng;
    s3.e   = s2o.e;
    unique case (s2o.rng)
      RNG_SMALL: begin
        s3.w[0] = e2;
        ysrc    = e2 >> 28;
      end
      RNG_MID: begin
        s3.w[0] = e4;
        ysrc    = e4 >> 24;
      end
      default: begin
        s3.w[0] = e6;
        ysrc    = e6 >> 16;
      end
    endcase
  end

  emsp_cdiv u_dr1 (.clk, .en, .num(RCP_W'(e2)), .rcp(RCP_6), .side_i(s3),
                   .quo(r1_q), .side_o(s3o));
  emsp_cdiv u_db (.clk, .en, .num(RCP_W'(e4) << 1), .rcp(RCP_15), .side_i('0),
                  .quo(b_q), .side_o());
  emsp_cdiv u_dc (.clk, .en, .num(RCP_W'(e6) << 12), .rcp(RCP_5040), .side_i('0),
                  .quo(c_q), .side_o());
  emsp_cdiv u_da (.clk, .en, .num(RCP_W'(e8) << 12), .rcp(RCP_362880), .side_i('0),
                  .quo(a_q), .side_o());

  for (genvar i = 0; i < NLANE; i++) begin : g_y
    fold_t fy;
    assign fy = fold_const(2'(i), s2o.rng);
    emsp_cdiv u_dy (.clk, .en, .num(RCP_W'(ysrc)), .rcp(fy.rcp), .side_i('0),
                    .quo(y_q[i]), .side_o());
  end

  // Fold denominators.
  side_t        s4_r, s4_nxt, s5o;
  logic [W-1:0] den_r   [NLANE];
  logic [W-1:0] den_nxt [NLANE];
  logic [2*W-1:0] fnum;
  logic [W-1:0] fq [NLANE];

  always_comb begin
    s4_nxt      = '0;
    s4_nxt.rng  = s3o.rng;
    s4_nxt.e    = s3o.e;
    s4_nxt.w[0] = r1_q;
    s4_nxt.w[1] = b_q;
    s4_nxt.w[2] = c_q;
    s4_nxt.w[3] = a_q;
    s4_nxt.w[4] = s3o.w[0];
  end

  for (genvar i = 0; i < NLANE; i++) begin : g_den
    fold_t fk;
    assign fk = fold_const(2'(i), s3o.rng);
    assign den_nxt[i] = fk.minus ? sub0(fk.k << 32, y_q[i]) : (fk.k << 32) + y_q[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= s4_nxt;
      for (int i = 0; i < NLANE; i++) begin
        den_r[i] <= den_nxt[i];
      end
    end
  end

  always_comb begin
    unique case (s4_r.rng)
      RNG_SMALL: fnum = (2*W)'(s4_r.w[4]) << FSH_SMALL;
      RNG_MID:   fnum = (2*W)'(s4_r.w[4]) << FSH_MID;
      default:   fnum = (2*W)'(s4_r.w[4]) << FSH_WIDE;
    endcase
  end

  emsp_div u_df0 (.clk, .en, .num(fnum), .den(den_r[0]), .side_i(s4_r),
                  .quo(fq[0]), .side_o(s5o));
  emsp_div u_df1 (.clk, .en, .num(fnum), .den(den_r[1]), .side_i('0),
                  .quo(fq[1]), .side_o());
  emsp_div u_df2 (.clk, .en, .num(fnum), .den(den_r[2]), .side_i('0),
                  .quo(fq[2]), .side_o());

  // Scale each term by its fold.
  side_t          s6o;
  logic [2*W-1:0] pt0, pt1, pt2;
  logic [W-1:0]   t0, t1, t2;

  emsp_mul u_mt0 (.clk, .en, .a(s5o.w[3]), .b(fq[0]), .side_i(s5o), .p(pt0),
                  .side_o(s6o));
  emsp_mul u_mt1 (.clk, .en, .a(s5o.w[1]), .b(fq[1]), .side_i('0), .p(pt1),
                  .side_o());
  emsp_mul u_mt2 (.clk, .en, .a(s5o.w[2]), .b(fq[2]), .side_i('0), .p(pt2),
                  .side_o());

  assign t0 = pt0[FW+W-1:FW];
  assign t1 = pt1[FW+W-1:FW];
  assign t2 = pt2[FW+W-1:FW];

  // Combine the terms over three short stages.
  side_t        c1_r, c2_r, c3_r;
  logic [W-1:0] inner_r, inner_nxt;
  logic [W-1:0] r2_r, r2_nxt, r3_r, r3_nxt;
  logic [W-1:0] r2b_r, r3b_r, r1x_r, r1x_nxt;
  logic [W-1:0] sum_r, sum_nxt;

  always_comb begin
    inner_nxt = '0;
    r2_nxt    = '0;
    r3_nxt    = '0;
    unique case (s6o.rng)
      RNG_SMALL: begin
        inner_nxt = sub0(s6o.w[1], t1);
      end
      RNG_MID: begin
        r2_nxt = s6o.w[1] + t1;
        r3_nxt = s6o.w[2] + t2;
      end
      default: begin
        inner_nxt = sub0(s6o.w[3], t0);
        r2_nxt    = sub0(s6o.w[1], t1);
        r3_nxt    = sub0(s6o.w[2], t2);
      end
    endcase
  end

  assign r1x_nxt = (c1_r.rng == RNG_MID) ? c1_r.w[0] : sub0(c1_r.w[0], inner_r);
  assign sum_nxt = (c2_r.rng == RNG_SMALL) ? r1x_r : sub0(r1x_r + r3b_r, r2b_r);

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r    <= s6o;
      inner_r <= inner_nxt;
      r2_r    <= r2_nxt;
      r3_r    <= r3_nxt;
      c2_r    <= c1_r;
      r1x_r   <= r1x_nxt;
      r2b_r   <= r2_r;
      r3b_r   <= r3_r;
      c3_r    <= c2_r;
      sum_r   <= sum_nxt;
    end
  end

  // Final product with E, then drop to the output format.
  logic [2*W-1:0]   pf;
  logic [W-1:0]     fin_t, fin_s;
  logic [OUT_W-1:0] res;

  emsp_mul u_mf (.clk, .en, .a(c3_r.e), .b(sum_r), .side_i('0), .p(pf), .side_o());

  always_comb begin
    fin_t = pf[FW+W-1:FW];
    fin_s = fin_t >> OUT_SH;
    res   = (|fin_s[W-1:OUT_W]) ? '1 : fin_s[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[BACK_LAT-2:0], q_rvld};
      out_vld_r <= vld_r[BACK_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/e_minus_sine_piecewise_series_top.sv -----
// E - sin E evaluator for Kepler solvers.
// Input channel: in_valid/in_ready with in_angle, the eccentric anomaly in
// unsigned Q2.30 radians; angles above pi are clamped to pi.
// Output channel: out_valid/out_ready with out_e_minus_sin in unsigned Q2.46,
// truncated, carrying full absolute precision for small angles.
// Each item gives exactly one result, in order.
// Throughput is one item per cycle while out_ready stays high. An accepted
// item passes a front register, a two-entry queue, then an 82-stage back
// pipeline and an output register. The back pipeline's length is set by the
// restoring dividers of the folds, which retire one quotient bit per stage,
// a four-stage reciprocal multiplication for the constant divisions, and five
// chained two-stage 64x64 multipliers.
// When out_ready is low with a result pending, the back pipeline freezes; the
// queue and front register still absorb up to three more items before in_ready
// falls. Reset (rst_n low, synchronous) empties the queue and drops every item
// in flight. There is no configuration and no state between items.
`default_nettype none
`include "assert_macros.svh"
module e_minus_sine_piecewise_series_top import emsp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ANG_W-1:0] in_angle,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [OUT_W-1:0]      out_e_minus_sin
);

  logic  q_wvld;
  item_t q_wdata;
  logic  q_full;
  logic  q_rvld;
  item_t q_rdata;
  logic  q_pop;

  emsp_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_angle,
    .q_wvld, .q_wdata, .q_full
  );

  emsp_fifo u_fifo (
    .clk, .rst_n, .q_wvld, .q_wdata, .q_full, .q_rvld, .q_rdata, .q_pop
  );

  emsp_back u_back (
    .clk, .rst_n, .q_rvld, .q_rdata, .q_pop,
    .out_valid, .out_ready, .out_e_minus_sin
  );

  `EMSP_ASSERT_IMP(a_stall_no_pop, out_valid && !out_ready, !q_pop)
  `EMSP_ASSERT_NXT(a_accept_loads_front, in_valid && in_ready, q_wvld)
  `EMSP_ASSERT_IMP(a_full_has_data, q_full, q_rvld)

endmodule
`default_nettype wire

// ----- tb/emsp_checker.sv -----
module emsp_checker
  import emsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [ANG_W-1:0] in_angle,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [OUT_W-1:0] out_e_minus_sin,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [OUT_W-1:0] expected_q[$];

  function automatic logic [63:0] floor0(input logic [63:0] a, input logic [63:0] b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  // Quotient of a full 128-bit product, saturating when it needs more than 64 bits.
  function automatic logic [63:0] mul_quot(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] d);
    logic [127:0] p;
    logic [127:0] q;
    if (d == 64'd0) begin
      return '1;
    end
    p = {64'd0, a} * {64'd0, b};
    q = p / {64'd0, d};
    return (q[127:64] != 64'd0) ? '1 : q[63:0];
  endfunction

  function automatic logic [63:0] nested_fold(input logic [63:0] num, input int nf,
                                              input logic [63:0] k, input logic [63:0] y32,
                                              input bit minus);
    logic [63:0] den;
    den = k << 32;
    den = minus ? floor0(den, y32) : den + y32;
    return mul_quot(num, 64'd1 << (92 - nf), den);
  endfunction

  function automatic logic [OUT_W-1:0] e_minus_sin_of(input logic [ANG_W-1:0] angle);
    logic [63:0] ang, e, e2, e4, e6, e8, b, c, a, y, r1, r2, r3, sum, res, q1, q2, q3;
    ang = {32'd0, angle};
    if (ang > {32'd0, ANG_MAX}) begin
      ang = {32'd0, ANG_MAX};
    end
    e  = ang << E_SH;
    e2 = mul_shift(e, e, FW);
    e4 = mul_shift(e2, e2, 64);
    b  = mul_quot(e4, 64'd2, 64'd15);
    r1 = e2 / 64'd6;
    if (e <= SMALL_LIMIT) begin
      q1  = nested_fold(e2, 60, 64'd42, (e2 >> 28) / 64'd72, 1'b0);
      sum = floor0(r1, floor0(b, mul_shift(b, q1, FW)));
    end else begin
      e6 = mul_shift(e4, e2, 68);
      c  = mul_quot(e6, 64'd1 << 12, 64'd5040);
      if (e <= MID_LIMIT) begin
        q2 = nested_fold(e4, 56, 64'd3024, (e4 >> 24) / 64'd17160, 1'b1);
        q3 = nested_fold(e4, 56, 64'd7920, (e4 >> 24) / 64'd57120, 1'b1);
        r2 = b + mul_shift(b, q2, FW);
        r3 = c + mul_shift(c, q3, FW);
      end else begin
        e8 = mul_shift(e4, e4, 64);
        a  = mul_quot(e8, 64'd1 << 12, 64'd362880);
        y  = e6 >> 16;
        q1 = nested_fold(e6, 48, 64'd3603600, y / 64'd39070080, 1'b0);
        q2 = nested_fold(e6, 48, 64'd332640, y / 64'd8910720, 1'b0);
        q3 = nested_fold(e6, 48, 64'd1235520, y / 64'd19535040, 1'b0);
        r1 = floor0(r1, floor0(a, mul_shift(a, q1, FW)));
        r2 = floor0(b, mul_shift(b, q2, FW));
        r3 = floor0(c, mul_shift(c, q3, FW));
      end
      sum = floor0(r1 + r3, r2);
    end
    res = mul_shift(e, sum, FW) >> OUT_SH;
    if (res > {16'd0, {OUT_W{1'b1}}}) begin
      res = {16'd0, {OUT_W{1'b1}}};
    end
    return res[OUT_W-1:0];
  endfunction

  initial errors = 0;
  assign pending = expected_q.size();

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_q.push_back(e_minus_sin_of(in_angle));
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("e_minus_sin: result %0h with no item outstanding", out_e_minus_sin);
          errors++;
        end else begin
          if (out_e_minus_sin !== expected_q[0]) begin
            $error("e_minus_sin: expected %0h, actual %0h", expected_q[0], out_e_minus_sin);
            errors++;
          end
          void'(expected_q.pop_front());
        end
      end
    end
  end
endmodule

// ----- tb/testbench.sv -----
module testbench;
  import emsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [ANG_W-1:0] in_angle;
  logic             out_valid;
  logic             out_ready;
  logic [OUT_W-1:0] out_e_minus_sin;
  int               errors;
  int               pending;
  int               cycles;
  int               send_idle;
  int               recv_idle;
  int               hold_cnt;
  bit               long_hold;

  e_minus_sine_piecewise_series_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_angle(in_angle),
    .out_valid(out_valid), .out_ready(out_ready), .out_e_minus_sin(out_e_minus_sin)
  );

  emsp_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_angle(in_angle),
    .out_valid(out_valid), .out_ready(out_ready), .out_e_minus_sin(out_e_minus_sin),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // The long hold keeps out_ready low so the pipeline and its queue fill up.
  always @(negedge clk) begin
    if (long_hold) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
      if (hold_cnt >= 400) begin
        long_hold = 1'b0;
      end
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_angle(input logic [ANG_W-1:0] a);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [ANG_W-1:0] random_angle();
    logic [ANG_W-1:0] small_top, mid_top;
    small_top = ANG_W'(SMALL_LIMIT >> E_SH);
    mid_top   = ANG_W'(MID_LIMIT >> E_SH);
    case ($urandom_range(9))
      0, 1:    return $urandom_range(small_top + 4, 0);
      2, 3, 4: return $urandom_range(mid_top + 4, small_top - 4);
      5, 6, 7: return $urandom_range(ANG_MAX, mid_top - 4);
      8:       return $urandom_range(32'hFFFF_FFFF, ANG_MAX);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [ANG_W-1:0] small_top, mid_top;
    small_top = ANG_W'(SMALL_LIMIT >> E_SH);
    mid_top   = ANG_W'(MID_LIMIT >> E_SH);
    cycles    = 0;
    hold_cnt  = 0;
    long_hold = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    in_valid  = 1'b0;
    in_angle  = '0;
    out_ready = 1'b0;
    rst_n     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Range boundaries, clamping above pi and the field extremes.
    send_angle(32'd0);
    send_angle(32'd1);
    send_angle(32'd2);
    send_angle(small_top - 1);
    send_angle(small_top);
    send_angle(small_top + 1);
    send_angle(mid_top - 1);
    send_angle(mid_top);
    send_angle(mid_top + 1);
    send_angle(32'h4000_0000);
    send_angle(ANG_MAX - 1);
    send_angle(ANG_MAX);
    send_angle(ANG_MAX + 1);
    send_angle(32'hFFFF_FFFF);
    send_angle(32'h5555_5555);
    send_angle(32'hAAAA_AAAA);
    send_angle(32'h8000_0000);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 80; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 80; end
        default: begin send_idle = 27; recv_idle = 27; end
      endcase
      for (int n = 0; n < 150; n++) begin
        if (phase == 0 && n == 40) begin
          long_hold = 1'b1;
        end
        send_angle(random_angle());
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
